@@ src/md5_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package md5_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } md5_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       absorb;      // write input byte into the block
        logic       pad_write;   // write one padding byte at pad_pos
        logic [5:0] pad_pos;
        logic [7:0] pad_byte;
        logic       start;       // load working words from chaining words
        logic       round;       // run one round
        logic [5:0] round_idx;
        logic       fold;        // add working words into chaining words
        logic       init;        // restore initial chaining words
    } md5_cmd_t;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [7:0] PAD_MARK = 8'h80;

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        begin
            unique case (r)
                6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        begin
            unique case ({r[5:4], r[1:0]})
                4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

endpackage
`default_nettype wire

@@ src/md5_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface md5_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;
    modport source (output valid, output op, output data_byte, input ready);
    modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface
`default_nettype wire

@@ src/md5_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module md5_datapath (
    input  wire logic             clk,
    input  wire md5_pkg::md5_cmd_t cmd,
    input  wire logic [5:0]       wr_pos,
    input  wire logic [7:0]       in_byte,
    input  wire logic [1:0]       out_sel,
    output logic [31:0]           out_word
);
    // The block is held as sixteen little-endian words, written a byte at a time.
    logic [31:0] word_reg [16];
    logic [31:0] hash_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] f, sum, rot, w;
    logic [3:0]  k;
    logic [5:0]  r;

    always_ff @(posedge clk)
    begin
        if (cmd.absorb)
        begin
            word_reg[wr_pos[5:2]][{wr_pos[1:0], 3'd0} +: 8] <= in_byte;
        end
        else if (cmd.pad_write)
        begin
            word_reg[cmd.pad_pos[5:2]][{cmd.pad_pos[1:0], 3'd0} +: 8] <= cmd.pad_byte;
        end
    end

    assign r = cmd.round_idx;

    always_comb
    begin
        case (r[5:4])
            2'd0:
            begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                k = r[3:0];
            end
            2'd1:
            begin
                f = (d_reg & b_reg) | (~d_reg & c_reg);
                k = 4'((5 * r) + 1);
            end
            2'd2:
            begin
                f = b_reg ^ c_reg ^ d_reg;
                k = 4'((3 * r) + 5);
            end
            default:
            begin
                f = c_reg ^ (b_reg | ~d_reg);
                k = 4'(7 * r);
            end
        endcase
        w   = word_reg[k];
        sum = a_reg + f + md5_pkg::round_const(r) + w;
        rot = (sum << md5_pkg::rot_amount(r))
            | (sum >> (6'd32 - {1'b0, md5_pkg::rot_amount(r)}));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            hash_reg[0] <= md5_pkg::INIT_A;
            hash_reg[1] <= md5_pkg::INIT_B;
            hash_reg[2] <= md5_pkg::INIT_C;
            hash_reg[3] <= md5_pkg::INIT_D;
        end
        else if (cmd.fold)
        begin
            hash_reg[0] <= hash_reg[0] + a_reg;
            hash_reg[1] <= hash_reg[1] + b_reg;
            hash_reg[2] <= hash_reg[2] + c_reg;
            hash_reg[3] <= hash_reg[3] + d_reg;
        end
        if (cmd.start)
        begin
            a_reg <= hash_reg[0];
            b_reg <= hash_reg[1];
            c_reg <= hash_reg[2];
            d_reg <= hash_reg[3];
        end
        else if (cmd.round)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
    end

    assign out_word = hash_reg[out_sel];
endmodule
`default_nettype wire

@@ src/md5_control.sv @@
`timescale 1ns / 1ps
`default_nettype none
module md5_control (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_op,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             out_idx,
    output logic [5:0]             wr_pos,
    output md5_pkg::md5_cmd_t      cmd
);
    md5_pkg::md5_state_t state_reg, state_next;
    logic [5:0]  count_reg, count_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  pos_reg, pos_next;     // padding write pointer
    logic [5:0]  round_reg, round_next;
    logic        final_reg, final_next; // current compression is the last one
    logic        spill_reg, spill_next; // padding the second block of a spilled pad
    logic [1:0]  idx_reg, idx_next;
    logic        take;
    logic        rst_seen_reg;

    assign take = in_valid && in_ready;
    assign wr_pos = count_reg;
    assign out_idx = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= md5_pkg::ST_IDLE;
            count_reg <= '0;
            bits_reg <= '0;
            pos_reg <= '0;
            round_reg <= '0;
            final_reg <= 1'b0;
            spill_reg <= 1'b0;
            idx_reg <= '0;
            rst_seen_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            bits_reg <= bits_next;
            pos_reg <= pos_next;
            round_reg <= round_next;
            final_reg <= final_next;
            spill_reg <= spill_next;
            idx_reg <= idx_next;
            rst_seen_reg <= 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        bits_next = bits_reg;
        pos_next = pos_reg;
        round_next = round_reg;
        final_next = final_reg;
        spill_next = spill_reg;
        idx_next = idx_reg;
        unique case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                if (take && !in_op)
                begin
                    bits_next = bits_reg + 64'd8;
                    count_next = count_reg + 6'd1;
                    if (count_reg == 6'd63)
                    begin
                        final_next = 1'b0;
                        round_next = '0;
                        state_next = md5_pkg::ST_ROUND;
                    end
                end
                else if (take)
                begin
                    pos_next = count_reg;
                    state_next = md5_pkg::ST_PAD;
                end
            end
            md5_pkg::ST_PAD:
            begin
                pos_next = pos_reg + 6'd1;
                if (pos_reg == 6'd63)
                begin
                    // Either the length block is done or the marker spilled over.
                    final_next = (count_reg < md5_pkg::LEN_POS);
                    count_next = md5_pkg::LEN_POS;
                    spill_next = 1'b0;
                    round_next = '0;
                    state_next = md5_pkg::ST_ROUND;
                end
            end
            md5_pkg::ST_ROUND:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = md5_pkg::ST_FOLD;
                end
            end
            md5_pkg::ST_FOLD:
            begin
                if (final_reg)
                begin
                    idx_next = '0;
                    state_next = md5_pkg::ST_EMIT;
                end
                else if (count_reg == md5_pkg::LEN_POS)
                begin
                    // Overflowed padding: second block is zeros plus length.
                    count_next = '0;
                    spill_next = 1'b1;
                    pos_next = '0;
                    state_next = md5_pkg::ST_PAD;
                end
                else
                begin
                    state_next = md5_pkg::ST_IDLE;
                end
            end
            md5_pkg::ST_EMIT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        count_next = '0;
                        bits_next = '0;
                        state_next = md5_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = md5_pkg::ST_IDLE;
            end
        endcase
    end

    // Pad byte for position p: marker at the stop point, length from 56 up if stop < 56.
    // The second block of a spilled pad starts at zero and carries no marker.
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                in_ready = rst_seen_reg;
                cmd.absorb = take && !in_op;
                cmd.start = take && !in_op && (count_reg == 6'd63);
                // The chaining words are loaded at the first clock edge out of reset.
                cmd.init = !rst_seen_reg;
            end
            md5_pkg::ST_PAD:
            begin
                cmd.pad_pos = pos_reg;
                if (pos_reg < count_reg)
                begin
                    cmd.pad_write = 1'b0;
                end
                else
                begin
                    cmd.pad_write = 1'b1;
                end
                if (pos_reg == count_reg && !spill_reg)
                begin
                    cmd.pad_byte = md5_pkg::PAD_MARK;
                end
                else if (pos_reg >= md5_pkg::LEN_POS && count_reg < md5_pkg::LEN_POS)
                begin
                    cmd.pad_byte = bits_reg[{pos_reg[2:0], 3'd0} +: 8];
                end
                else
                begin
                    cmd.pad_byte = 8'h00;
                end
                cmd.start = (pos_reg == 6'd63);
            end
            md5_pkg::ST_ROUND:
            begin
                cmd.round = 1'b1;
                cmd.round_idx = round_reg;
            end
            md5_pkg::ST_FOLD:
            begin
                cmd.fold = 1'b1;
            end
            md5_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                cmd.init = out_ready && (idx_reg == 2'd3);
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != md5_pkg::ST_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_round_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == md5_pkg::ST_ROUND && round_reg != 6'd63)
        |=> (state_reg == md5_pkg::ST_ROUND && round_reg == $past(round_reg) + 6'd1))
        else $error("round counter skipped");
    a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == md5_pkg::ST_EMIT && out_ready && idx_reg == 2'd3)
        |=> (state_reg == md5_pkg::ST_IDLE && count_reg == 6'd0 && bits_reg == 64'd0))
        else $error("state not reinitialised after digest");
`endif
endmodule
`default_nettype wire

@@ src/md5_message_digest.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Payload
// in_ch    in   op, data_byte
// out_ch   out  digest_word, word_index, last_word
//
// An absorbed byte is written into the block; every 64th byte starts the round unit
// (one round a cycle) and then the final addition.
// Finish with n bytes held writes padding from position n to the block end, then
// compresses; from n = 56 up the length spills into a second block, which is padded
// and compressed again. Then four output transfers, one a cycle at best.
// Reset is asynchronous; input ready rises after the first clock edge out of reset.
// A stalled output simply holds the current digest word, and input waits meanwhile.
module md5_message_digest (
    input wire logic    clk,
    input wire logic    rst_n,
    md5_in_if.sink      in_ch,
    md5_out_if.source   out_ch
);
    md5_pkg::md5_cmd_t cmd;
    logic [5:0]  wr_pos;
    logic [1:0]  out_idx;
    logic [31:0] out_word;

    md5_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_op     (in_ch.op),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_idx   (out_idx),
        .wr_pos    (wr_pos),
        .cmd       (cmd)
    );

    md5_datapath u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .wr_pos   (wr_pos),
        .in_byte  (in_ch.data_byte),
        .out_sel  (out_idx),
        .out_word (out_word)
    );

    assign out_ch.digest_word = out_word;
    assign out_ch.word_index = out_idx;
    assign out_ch.last_word = (out_idx == 2'd3);
endmodule
`default_nettype wire
